// ===== rtl/wbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbc_pkg
// Shared types and constants of the write-back block cache policy controller.
// ----------------------------------------------------------------------------
package wbc_pkg;

  localparam int TAG_W     = 24;  // disk block address width
  localparam int REQ_W     = 2;   // request kind width
  localparam int OUT_WAY_W = 2;   // way field width in a result item
  localparam int IN_DATA_W = 24;  // input tdata width (block number, whole bytes)
  localparam int OUT_DATA_W = 32; // result tdata width, padded to whole bytes

  // Request kinds; code 3 is ignored
  typedef enum logic [REQ_W-1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FLUSH = 2'd2
  } wbc_req_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,  // waiting for a request
    ST_PRE  = 2'd1,  // read: way 0 data arrives as first victim candidate
    ST_EVAL = 2'd2,  // one scanned way's data arrives and is updated
    ST_FIN  = 2'd3   // read miss: victim refilled, result issued
  } wbc_state_t;

  // One result item
  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic                 writeback;
    logic [TAG_W-1:0]     writeback_block;
    logic                 fill;
    logic                 direct_write;
    logic                 last;
  } wbc_res_t;

endpackage

// ===== rtl/wbc_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbc_mem
// Way table: tag, age and dirty mark per way. One write port, one read port,
// registered read data. Per-entry valid bits make unwritten entries read zero.
// ----------------------------------------------------------------------------
module wbc_mem #(
  parameter int DEPTH = 3,
  parameter int WIDTH = 41
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Written marks, cleared by reset so every entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/wbc_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbc_out
// Result register: holds one item for the downstream side and frees the
// slot in the same cycle it is taken.
// ----------------------------------------------------------------------------
module wbc_out
  import wbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  wbc_res_t              res,
  output logic                  slot_free,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic     vld_r;
  logic     vld_nxt;
  wbc_res_t res_r;

  assign slot_free = !vld_r || out_tready;

  // Valid flag
  always_comb begin
    vld_nxt = vld_r;
    if (push) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {2'b00, res_r.direct_write, res_r.fill, res_r.writeback_block,
                       res_r.writeback, res_r.way, res_r.hit};

endmodule

// ===== rtl/wbc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbc_ctrl
// Scan sequencer: walks the ways one per cycle through the way table
// unless a full result slot holds the scan, updates ages and dirty marks
// by read-modify-write, tracks the victim and issues result items.
// ----------------------------------------------------------------------------
module wbc_ctrl
  import wbc_pkg::*;
#(
  parameter int WAYS     = 3,
  parameter int AGE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request side
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [REQ_W-1:0]                      in_req,
  input  logic [TAG_W-1:0]                      in_bno,
  // way table
  output logic                                  wr_en,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] wr_addr,
  output logic [TAG_W+AGE_BITS:0]               wr_data,
  output logic                                  rd_en,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] rd_addr,
  input  logic [TAG_W+AGE_BITS:0]               rd_data,
  // result side
  input  logic                                  slot_free,
  output logic                                  push,
  output wbc_res_t                              res
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W = TAG_W + AGE_BITS + 1;
  localparam logic [WAY_W-1:0]    LAST_WAY = WAY_W'(WAYS - 1);
  localparam logic [WAY_W:0]      WAYS_C   = (WAY_W + 1)'(WAYS);
  localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};

  wbc_state_t           state_r, state_nxt;
  wbc_req_t             req_r, req_nxt;
  logic [TAG_W-1:0]     bno_r, bno_nxt;
  logic [WAY_W-1:0]     cur_r, cur_nxt;    // way whose data arrives this cycle
  logic [WAY_W-1:0]     cnt_r, cnt_nxt;    // ways already evaluated
  logic [WAY_W-1:0]     ptr_r, ptr_nxt;    // rotating read scan pointer
  logic [WAY_W-1:0]     pick_r, pick_nxt;  // victim candidate
  logic [AGE_BITS-1:0]  pick_age_r, pick_age_nxt;
  logic [TAG_W-1:0]     pick_tag_r, pick_tag_nxt;
  logic                 pick_dirty_r, pick_dirty_nxt;

  // Entry fields of the way just read
  logic [TAG_W-1:0]     r_tag;
  logic [AGE_BITS-1:0]  r_age;
  logic                 r_dirty;
  logic [AGE_BITS-1:0]  aged;
  logic [AGE_BITS-1:0]  eff_age;

  // Way arithmetic
  logic [WAY_W:0]               cur_inc;
  logic [WAY_W-1:0]             cur_adv;
  logic [WAY_W:0]               ptr_inc;
  logic [WAY_W-1:0]             ptr_adv;
  logic [WAY_W+OUT_WAY_W-1:0]   cur_ext;
  logic [WAY_W+OUT_WAY_W-1:0]   pick_ext;

  // Decisions in the evaluate state
  logic tag_hit;
  logic last_way;
  logic eval_out;
  logic eval_go;
  logic eval_done;

  assign r_tag   = rd_data[ENT_W-1 -: TAG_W];
  assign r_age   = rd_data[AGE_BITS:1];
  assign r_dirty = rd_data[0];
  assign aged    = (r_age == AGE_MAX) ? r_age : r_age + 1'b1;
  // way 0 may be both the candidate and the way being aged
  assign eff_age = (pick_r == cur_r) ? aged : pick_age_r;

  assign cur_inc  = {1'b0, cur_r} + 1'b1;
  assign cur_adv  = (cur_inc >= WAYS_C) ? '0 : cur_inc[WAY_W-1:0];
  assign ptr_inc  = {1'b0, ptr_r} + 1'b1;
  assign ptr_adv  = (ptr_inc >= WAYS_C) ? '0 : ptr_inc[WAY_W-1:0];
  assign cur_ext  = {{OUT_WAY_W{1'b0}}, cur_r};
  assign pick_ext = {{OUT_WAY_W{1'b0}}, pick_r};

  assign tag_hit   = (req_r != REQ_FLUSH) && (r_tag == bno_r);
  assign last_way  = (cnt_r == LAST_WAY);
  assign eval_out  = (req_r == REQ_FLUSH) || tag_hit || ((req_r == REQ_WRITE) && last_way);
  assign eval_go   = !eval_out || slot_free;
  assign eval_done = tag_hit || last_way;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          priority case (in_req)
            REQ_READ:            state_nxt = ST_PRE;
            REQ_WRITE, REQ_FLUSH: state_nxt = ST_EVAL;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PRE:  state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (eval_go && eval_done) begin
          state_nxt = ((req_r == REQ_READ) && !tag_hit) ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = rd_data;
    push           = 1'b0;
    res            = '0;
    req_nxt        = req_r;
    bno_nxt        = bno_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    pick_nxt       = pick_r;
    pick_age_nxt   = pick_age_r;
    pick_tag_nxt   = pick_tag_r;
    pick_dirty_nxt = pick_dirty_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        req_nxt  = wbc_req_t'(in_req);
        bno_nxt  = in_bno;
        cur_nxt  = '0;
        cnt_nxt  = '0;
        // way 0 first: victim seed for reads, first way for writes and flushes
        rd_en    = in_valid;
      end
      ST_PRE: begin
        pick_nxt       = '0;
        pick_age_nxt   = r_age;
        pick_tag_nxt   = r_tag;
        pick_dirty_nxt = r_dirty;
        rd_en          = 1'b1;
        rd_addr        = ptr_adv;
        cur_nxt        = ptr_adv;
      end
      ST_EVAL: begin
        if (eval_go) begin
          wr_en = 1'b1;
          unique case (req_r)
            REQ_READ: begin
              if (tag_hit) begin
                wr_data  = {r_tag, {AGE_BITS{1'b0}}, r_dirty};
                push     = 1'b1;
                res.hit  = 1'b1;
                res.way  = cur_ext[OUT_WAY_W-1:0];
                res.last = 1'b1;
                ptr_nxt  = cur_r;
              end else begin
                wr_data = {r_tag, aged, r_dirty};
                // strict compare keeps the earlier candidate on a tie
                if (eff_age < aged) begin
                  pick_nxt       = cur_r;
                  pick_age_nxt   = aged;
                  pick_tag_nxt   = r_tag;
                  pick_dirty_nxt = r_dirty;
                end else begin
                  pick_age_nxt = eff_age;
                end
              end
            end
            REQ_WRITE: begin
              if (tag_hit) begin
                wr_data  = {r_tag, {AGE_BITS{1'b0}}, 1'b1};
                push     = 1'b1;
                res.hit  = 1'b1;
                res.way  = cur_ext[OUT_WAY_W-1:0];
                res.last = 1'b1;
              end else begin
                wr_data = {r_tag, aged, r_dirty};
                if (last_way) begin
                  push             = 1'b1;
                  res.direct_write = 1'b1;
                  res.last         = 1'b1;
                end
              end
            end
            REQ_FLUSH: begin
              wr_data             = {r_tag, r_age, 1'b0};
              push                = 1'b1;
              res.way             = cur_ext[OUT_WAY_W-1:0];
              res.writeback       = r_dirty;
              res.writeback_block = r_dirty ? r_tag : '0;
              res.last            = last_way;
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
          // issue the next way of the scan
          if (!eval_done) begin
            rd_en   = 1'b1;
            rd_addr = (req_r == REQ_READ) ? cur_adv : cur_inc[WAY_W-1:0];
            cur_nxt = (req_r == REQ_READ) ? cur_adv : cur_inc[WAY_W-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          wr_en               = 1'b1;
          wr_addr             = pick_r;
          wr_data             = {bno_r, {AGE_BITS{1'b0}}, 1'b0};
          push                = 1'b1;
          res.way             = pick_ext[OUT_WAY_W-1:0];
          res.writeback       = pick_dirty_r;
          res.writeback_block = pick_dirty_r ? pick_tag_r : '0;
          res.fill            = 1'b1;
          res.last            = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // Request and scan payload
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    bno_r        <= bno_nxt;
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    pick_r       <= pick_nxt;
    pick_age_r   <= pick_age_nxt;
    pick_tag_r   <= pick_tag_nxt;
    pick_dirty_r <= pick_dirty_nxt;
  end

`ifndef ASSERT_OFF
  // A result is only issued into a free output slot
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> slot_free)
    else $error("result issued while output slot is full");

  // The scan never reads the way it is writing back in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("way table read and write collide");

  // Scan pointer and current way stay inside the table
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, ptr_r} < WAYS_C))
    else $error("scan pointer out of range");

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> ({1'b0, cur_r} < WAYS_C))
    else $error("evaluated way out of range");

  // A read miss always ends with a fill result
  a_fin_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && slot_free) |-> (push && res.fill && res.last))
    else $error("read miss finished without fill result");
`endif

endmodule

// ===== rtl/write_back_block_cache_policy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// write_back_block_cache_policy
// Tag-and-policy controller of a small fully associative write-back disk
// block cache with saturating age counters per way.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                     | tuser     | tlast
//  in_     | in  | block_number [23:0]       | req_type  | -
//  out_    | out | hit, way, writeback,      | -         | last
//          |     | writeback_block, fill,    |           |
//          |     | direct_write              |           |
//
//  Read: accept, victim seed from way 0, a step per scanned way from the way
//  after the scan pointer, refill on a miss. Write and flush: accept, scan from way 0.
//  The single read port of the way table sets the one-way-per-cycle scan.
//  Reset clears the scan pointer and marks all ways unwritten (tag, age and
//  dirty read as zero); no clearing pass. A full result register holds the
//  scan at the cycle that would issue a result; the next request is taken
//  while the last result still waits.
// ----------------------------------------------------------------------------
module write_back_block_cache_policy
  import wbc_pkg::*;
#(
  parameter int WAYS     = 3,
  parameter int AGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [23:0] block_number
  input  logic [REQ_W-1:0]      in_tuser,   // [1:0] req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] hit, [2:1] way, [3] writeback,
                                            // [27:4] writeback_block, [28] fill,
                                            // [29] direct_write, [31:30] zero
  output logic                  out_tlast   // last
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W = TAG_W + AGE_BITS + 1;

  logic              wr_en;
  logic [WAY_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic              rd_en;
  logic [WAY_W-1:0]  rd_addr;
  logic [ENT_W-1:0]  rd_data;
  logic              slot_free;
  logic              push;
  wbc_res_t          res;

  // Way table
  wbc_mem #(
    .DEPTH (WAYS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Scan sequencer
  wbc_ctrl #(
    .WAYS     (WAYS),
    .AGE_BITS (AGE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .in_bno    (in_tdata[TAG_W-1:0]),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .slot_free (slot_free),
    .push      (push),
    .res       (res)
  );

  // Result register
  wbc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the write-back block cache policy controller.
// Requests go out on the input stream from a queue of pending items. A
// predictor of its own follows the tags, ages, dirty marks and the scan
// pointer of the cache, and the results it expects are checked in order
// against every item that leaves the result stream. A directed opening, a
// short calm run of write misses, a few read misses on absent blocks and a
// long random mix of reads, writes and flushes on a small set of blocks
// follow each other. The sender idles in bursts and the receiver stalls on
// its own pattern, with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import wbc_pkg::*;

  localparam int N_WAYS     = 3;
  localparam int AGE_W      = 16;
  localparam int N_RANDOM   = 400;
  localparam int N_AGE_RUN  = 4;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_LEN   = 20;
  localparam int MAX_REPORT = 10;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;  // not a request, ignored

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [TAG_W-1:0] blk;
  } cache_req_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [23:0] block_number
  logic [REQ_W-1:0]      in_tuser;   // [1:0] req_type
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [0] hit, [2:1] way, [3] writeback,
                                     // [27:4] writeback_block, [28] fill,
                                     // [29] direct_write, [31:30] zero
  logic                  out_tlast;  // last

  cache_req_t pending_requests[$];
  wbc_res_t   expected_results[$];
  int         fail_cnt;

  // predictor's own copy of the cache
  logic [TAG_W-1:0] way_tag[N_WAYS];
  logic [AGE_W-1:0] way_age[N_WAYS];
  logic             way_dirty[N_WAYS];
  int               scan_ptr;

  // pacing controls
  bit calm;           // no idling on either side
  bit squeeze_go;     // ask the receiver for its long hold-off
  bit squeeze_done;
  bit in_done;        // set when the offered item was taken
  int gap_left, burst_left;
  int hold_left, stall_left, rdy_left;

  write_back_block_cache_policy #(
    .WAYS     (N_WAYS),
    .AGE_BITS (AGE_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic wbc_res_t make_result(logic h, int w, logic wbk,
                                           logic [TAG_W-1:0] blk, logic f,
                                           logic dw, logic lst);
    wbc_res_t r;
    r.hit             = h;
    r.way             = OUT_WAY_W'(w);
    r.writeback       = wbk;
    r.writeback_block = blk;
    r.fill            = f;
    r.direct_write    = dw;
    r.last            = lst;
    return r;
  endfunction

  function automatic void age_tick(int w);
    if (way_age[w] != AGE_MAX) way_age[w] = way_age[w] + 1'b1;
  endfunction

  // Works out the results of one accepted request and updates the cache copy
  task automatic cache_predict(input logic [REQ_W-1:0] req,
                               input logic [TAG_W-1:0] blk);
    int   pick;
    bit   found;
    logic wbk;
    found = 1'b0;
    pick  = 0;
    case (req)
      REQ_READ: begin
        // rotating scan from the way after the last one looked at
        for (int i = 0; i < N_WAYS && !found; i++) begin
          scan_ptr = (scan_ptr + 1 >= N_WAYS) ? 0 : scan_ptr + 1;
          if (way_tag[scan_ptr] == blk) begin
            way_age[scan_ptr] = '0;
            expected_results.push_back(make_result(1'b1, scan_ptr, 1'b0, '0,
                                                   1'b0, 1'b0, 1'b1));
            found = 1'b1;
          end else begin
            age_tick(scan_ptr);
            // strictly older only, so ties keep the earlier pick
            if (way_age[pick] < way_age[scan_ptr]) pick = scan_ptr;
          end
        end
        if (!found) begin
          wbk = way_dirty[pick];
          expected_results.push_back(make_result(1'b0, pick, wbk,
                                                 wbk ? way_tag[pick] : '0,
                                                 1'b1, 1'b0, 1'b1));
          way_dirty[pick] = 1'b0;
          way_tag[pick]   = blk;
          way_age[pick]   = '0;
        end
      end
      REQ_WRITE: begin
        for (int i = 0; i < N_WAYS && !found; i++) begin
          if (way_tag[i] == blk) begin
            way_age[i]   = '0;
            way_dirty[i] = 1'b1;
            expected_results.push_back(make_result(1'b1, i, 1'b0, '0,
                                                   1'b0, 1'b0, 1'b1));
            found = 1'b1;
          end else begin
            age_tick(i);
          end
        end
        // miss goes straight to disk, nothing allocated
        if (!found)
          expected_results.push_back(make_result(1'b0, 0, 1'b0, '0,
                                                 1'b0, 1'b1, 1'b1));
      end
      REQ_FLUSH: begin
        for (int i = 0; i < N_WAYS; i++) begin
          expected_results.push_back(make_result(1'b0, i, way_dirty[i],
                                                 way_dirty[i] ? way_tag[i] : '0,
                                                 1'b0, 1'b0, i == N_WAYS - 1));
          way_dirty[i] = 1'b0;
        end
      end
      default: ;  // unknown kind: no result, no change
    endcase
  endtask

  task automatic queue_request(input logic [REQ_W-1:0] req,
                               input logic [TAG_W-1:0] blk);
    cache_req_t it;
    it.req = req;
    it.blk = blk;
    pending_requests.push_back(it);
  endtask

  task automatic wait_drain();
    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // input side: take accepted items into the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      cache_predict(in_tuser, in_tdata);
      in_done = 1'b1;
    end
  end

  // driver: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_done)) begin
      in_done = 1'b0;
      if (gap_left > 0 && !calm) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_tuser  <= pending_requests[0].req;
        in_tdata  <= pending_requests[0].blk;
        in_tvalid <= 1'b1;
        void'(pending_requests.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 20)
                                                   : $urandom_range(8, 1);
          gap_left   = $urandom_range(8, 0);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (squeeze_go && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left    = HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rdy_left > 0) begin
        rdy_left--;
      end else begin
        rdy_left   = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 30)
                                                 : $urandom_range(10, 1);
        stall_left = $urandom_range(6, 1);
      end
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin : monitor
    wbc_res_t seen;
    wbc_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.hit             = out_tdata[0];
      seen.way             = out_tdata[2:1];
      seen.writeback       = out_tdata[3];
      seen.writeback_block = out_tdata[27:4];
      seen.fill            = out_tdata[28];
      seen.direct_write    = out_tdata[29];
      seen.last            = out_tlast;
      if (expected_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORT)
          $display("%0t: unexpected result item tdata=%h tlast=%b",
                   $realtime, out_tdata, out_tlast);
      end else begin
        want = expected_results.pop_front();
        if (seen !== want || out_tdata[31:30] !== 2'b00) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORT)
            $display({"%0t: result mismatch exp hit=%b way=%0d wb=%b blk=%h fill=%b ",
                      "dw=%b last=%b | got hit=%b way=%0d wb=%b blk=%h fill=%b ",
                      "dw=%b last=%b pad=%b"}, $realtime,
                     want.hit, want.way, want.writeback, want.writeback_block,
                     want.fill, want.direct_write, want.last,
                     seen.hit, seen.way, seen.writeback, seen.writeback_block,
                     seen.fill, seen.direct_write, seen.last, out_tdata[31:30]);
        end
      end
    end
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [TAG_W-1:0] pool[6];
    logic [TAG_W-1:0] sat_blk;
    logic [REQ_W-1:0] req;
    bit               clash;
    int               counted;
    int               r;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_READ;
    out_tready = 1'b0;
    fail_cnt   = 0;
    calm       = 1'b0;
    squeeze_go = 1'b0;
    squeeze_done = 1'b0;
    in_done    = 1'b0;
    gap_left   = 0;
    burst_left = 0;
    hold_left  = 0;
    stall_left = 0;
    rdy_left   = 0;
    scan_ptr   = 0;
    for (int i = 0; i < N_WAYS; i++) begin
      way_tag[i]   = '0;
      way_age[i]   = '0;
      way_dirty[i] = 1'b0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed opening: reset tags, hits, misses, dirty victims, flushes
    queue_request(REQ_READ,  24'h000000);  // every tag is zero after reset
    queue_request(REQ_WRITE, 24'h000000);
    queue_request(REQ_READ,  24'hFFFFFF);
    queue_request(REQ_WRITE, 24'hFFFFFF);
    queue_request(REQ_READ,  24'h123456);
    queue_request(REQ_WRITE, 24'hABCDEF);
    queue_request(REQ_FLUSH, 24'h000000);
    queue_request(REQ_FLUSH, 24'hFFFFFF);  // all clean now
    queue_request(REQ_NONE,  24'h5A5A5A);
    queue_request(REQ_WRITE, 24'h123456);
    queue_request(REQ_READ,  24'h800000);
    queue_request(REQ_READ,  24'h7FFFFF);
    queue_request(REQ_WRITE, 24'h555555);
    queue_request(REQ_WRITE, 24'h7FFFFF);
    queue_request(REQ_READ,  24'hAAAAAA);
    queue_request(REQ_READ,  24'h555555);
    queue_request(REQ_WRITE, 24'h800000);
    queue_request(REQ_READ,  24'hFFFFFF);
    queue_request(REQ_NONE,  24'hFFFFFF);
    queue_request(REQ_FLUSH, 24'h000000);
    queue_request(REQ_READ,  24'h000000);
    queue_request(REQ_WRITE, 24'h000000);
    queue_request(REQ_FLUSH, 24'h000000);
    wait_drain();

    // calm run of write misses on an absent block: every way ages alike
    do begin
      sat_blk = TAG_W'($urandom());
      clash   = 1'b0;
      for (int i = 0; i < N_WAYS; i++) if (way_tag[i] == sat_blk) clash = 1'b1;
    end while (clash);
    calm = 1'b1;
    for (int i = 0; i < N_AGE_RUN; i++) queue_request(REQ_WRITE, sat_blk);
    wait_drain();
    calm = 1'b0;

    // read misses: on equal ages the earlier pick must stay
    queue_request(REQ_READ,  sat_blk);
    queue_request(REQ_READ,  ~sat_blk);
    queue_request(REQ_WRITE, sat_blk);
    queue_request(REQ_READ,  sat_blk ^ 24'h000F0F);
    queue_request(REQ_FLUSH, 24'h000000);
    wait_drain();

    // random mix, mostly on a small set of blocks so hits are common
    pool[0] = 24'h000000;
    pool[1] = 24'hFFFFFF;
    for (int i = 2; i < 6; i++) pool[i] = TAG_W'($urandom());
    squeeze_go = 1'b1;
    counted = 0;
    while (counted < N_RANDOM) begin
      r = $urandom_range(99, 0);
      if (r < 45)      req = REQ_READ;
      else if (r < 77) req = REQ_WRITE;
      else if (r < 93) req = REQ_FLUSH;
      else             req = REQ_NONE;
      counted++;
      if ($urandom_range(3, 0) != 0) queue_request(req, pool[$urandom_range(5, 0)]);
      else                           queue_request(req, TAG_W'($urandom()));
    end
    wait_drain();
    repeat (TAIL_LEN) @(posedge clk);

    if (fail_cnt == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wbc_pkg.sv
rtl/wbc_mem.sv
rtl/wbc_out.sv
rtl/wbc_ctrl.sv
rtl/write_back_block_cache_policy.sv
bench/tb.sv
